// ===== src/vox_pkg.sv =====
package vox_pkg;

   // Largest accepted model extent along any axis
   localparam int unsigned MAX_DIM = 128;

   // Queue between the parser and the result stage
   localparam int unsigned VOX_QDEPTH = 2;
   localparam int unsigned VOX_QPTR_W = (VOX_QDEPTH > 1) ? $clog2(VOX_QDEPTH) : 1;
   localparam int unsigned VOX_QCNT_W = $clog2(VOX_QDEPTH + 1);

   // Chunk tags, first byte in the top byte
   localparam logic [31:0] TAG_SIZE = 32'h53495A45;
   localparam logic [31:0] TAG_XYZI = 32'h58595A49;

   // Result kinds
   localparam logic [1:0] KIND_DIMS    = 2'd0;
   localparam logic [1:0] KIND_WRITE   = 2'd1;
   localparam logic [1:0] KIND_EMPTY   = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // Error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_HEADER   = 3'd1;
   localparam logic [2:0] ERR_DIMS     = 3'd2;
   localparam logic [2:0] ERR_NO_XYZI  = 3'd3;
   localparam logic [2:0] ERR_BOUNDS   = 3'd4;
   localparam logic [2:0] ERR_EARLY    = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } vox_req_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [20:0]       write_address;
      logic signed [7:0] voxel_value;
      logic [7:0]        size_x;
      logic [7:0]        size_y;
      logic [7:0]        size_z;
      logic [2:0]        error_code;
      logic              final_result;
   } vox_rsp_type;

   // One classified result on its way to the result stage.
   // Address = (mul_a * mul_b + add_c) * scale + off_x, all zero unless a write.
   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] err;
      logic       fin;
      logic [7:0] value;
      logic [7:0] sx;
      logic [7:0] sy;
      logic [7:0] sz;
      logic [6:0] mul_a;
      logic [7:0] mul_b;
      logic [6:0] add_c;
      logic [7:0] scale;
      logic [6:0] off_x;
   } vox_entry_type;

   // Fixed 16-byte file header: "VOX ", 150, "MAIN", 0
   function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'h56;
         4'd1:    b = 8'h4F;
         4'd2:    b = 8'h58;
         4'd3:    b = 8'h20;
         4'd4:    b = 8'h96;
         4'd8:    b = 8'h4D;
         4'd9:    b = 8'h41;
         4'd10:   b = 8'h49;
         4'd11:   b = 8'h4E;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== src/vox_front.sv =====
module vox_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  vox_pkg::vox_req_type req,
   input  logic               swap_y_z,
   output logic               push,
   output vox_pkg::vox_entry_type entry
);
   import vox_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR, PH_SKIP4, PH_CHDR, PH_SKIPCH, PH_DIMS, PH_XHDR, PH_COUNT, PH_VOX
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] gather_ff, gather_in;
   logic [32:0] skip_ff, skip_in;
   logic [7:0]  ext_ff [3];
   logic [7:0]  ext_in [3];
   logic [31:0] vleft_ff, vleft_in;
   logic [7:0]  coord_ff [3];
   logic [7:0]  coord_in [3];
   logic        done_ff, done_in;

   logic [7:0]  b;
   logic [31:0] gword;
   logic [1:0]  dim_idx;
   logic        have;
   logic        oob;

   assign b     = req.data_byte;
   assign gword = gather_ff | (32'(b) << {cnt_ff[1:0], 3'b000});

   // Parse step for one accepted beat
   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      tag_in    = tag_ff;
      gather_in = gather_ff;
      skip_in   = skip_ff;
      ext_in    = ext_ff;
      vleft_in  = vleft_ff;
      coord_in  = coord_ff;
      done_in   = done_ff;
      have      = 1'b0;
      entry     = '0;
      dim_idx   = 2'd2;
      oob       = 1'b0;

      if (cnt_ff[4:2] inside {3'd0, 3'd3, 3'd6}) begin
         dim_idx = 2'd0;
      end else if (cnt_ff[4:2] inside {3'd1, 3'd4, 3'd7}) begin
         dim_idx = 2'd1;
      end

      if (take && !done_ff) begin
         case (phase_ff)
            PH_HDR: begin
               if (b != hdr_byte(cnt_ff[3:0])) gather_in = gather_ff | 32'd1;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff >= 5'd15) begin
                  if (gather_in[0]) begin
                     have      = 1'b1;
                     entry.kind = KIND_ERROR;
                     entry.err  = ERR_HEADER;
                  end
                  phase_in  = PH_SKIP4;
                  cnt_in    = '0;
                  gather_in = '0;
               end
            end
            PH_SKIP4: begin
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff >= 5'd3) begin
                  phase_in = PH_CHDR;
                  cnt_in   = '0;
               end
            end
            PH_CHDR, PH_XHDR: begin
               if (cnt_ff < 5'd4) tag_in = {tag_ff[23:0], b};
               else gather_in = gword;
               if (cnt_ff == 5'd7) begin
                  skip_in   = {1'b0, gword};
                  gather_in = '0;
               end
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff >= 5'd11) begin
                  skip_in   = skip_ff + {1'b0, gword};
                  gather_in = '0;
                  cnt_in    = '0;
                  if (phase_ff == PH_XHDR) begin
                     if (tag_ff != TAG_XYZI) begin
                        have       = 1'b1;
                        entry.kind = KIND_ERROR;
                        entry.err  = ERR_NO_XYZI;
                     end else begin
                        phase_in = PH_COUNT;
                     end
                  end else if (tag_ff == TAG_SIZE) begin
                     phase_in = PH_DIMS;
                  end else if (skip_in != '0) begin
                     phase_in = PH_SKIPCH;
                  end
                  if (phase_in != PH_SKIPCH) skip_in = '0;
                  tag_in = '0;
               end
            end
            PH_SKIPCH: begin
               if (skip_ff != '0) skip_in = skip_ff - 33'd1;
               if (skip_in == '0) phase_in = PH_CHDR;
            end
            PH_DIMS: begin
               gather_in = gword;
               if (cnt_ff[1:0] == 2'd3) begin
                  ext_in[dim_idx] = (gword >= 32'd1 && gword <= 32'(MAX_DIM)) ?
                                    gword[7:0] : 8'd0;
                  gather_in = '0;
               end
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff >= 5'd11) begin
                  cnt_in = '0;
                  have   = 1'b1;
                  if (ext_in[0] == '0 || ext_in[1] == '0 || ext_in[2] == '0) begin
                     entry.kind = KIND_ERROR;
                     entry.err  = ERR_DIMS;
                  end else begin
                     entry.kind = KIND_DIMS;
                     entry.sx   = ext_in[0];
                     entry.sy   = swap_y_z ? ext_in[2] : ext_in[1];
                     entry.sz   = swap_y_z ? ext_in[1] : ext_in[2];
                     phase_in   = PH_XHDR;
                  end
               end
            end
            PH_COUNT: begin
               gather_in = gword;
               cnt_in    = cnt_ff + 5'd1;
               if (cnt_ff >= 5'd3) begin
                  vleft_in  = gword;
                  gather_in = '0;
                  cnt_in    = '0;
                  if (gword == '0 || gword[31]) begin
                     have       = 1'b1;
                     entry.kind = KIND_EMPTY;
                     entry.fin  = 1'b1;
                     done_in    = 1'b1;
                  end else begin
                     phase_in = PH_VOX;
                  end
               end
            end
            PH_VOX: begin
               if (cnt_ff < 5'd3) begin
                  coord_in[cnt_ff[1:0]] = b;
                  cnt_in = cnt_ff + 5'd1;
               end else begin
                  cnt_in = '0;
                  have   = 1'b1;
                  // signed-negative coordinates have the top bit set
                  oob = coord_ff[0][7] || coord_ff[1][7] || coord_ff[2][7] ||
                        coord_ff[0] >= ext_ff[0] || coord_ff[1] >= ext_ff[1] ||
                        coord_ff[2] >= ext_ff[2];
                  if (oob) begin
                     entry.kind = KIND_ERROR;
                     entry.err  = ERR_BOUNDS;
                  end else begin
                     entry.kind  = KIND_WRITE;
                     entry.value = b;
                     entry.mul_a = swap_y_z ? coord_ff[1][6:0] : coord_ff[2][6:0];
                     entry.mul_b = swap_y_z ? ext_ff[2] : ext_ff[1];
                     entry.add_c = swap_y_z ? coord_ff[2][6:0] : coord_ff[1][6:0];
                     entry.scale = ext_ff[0];
                     entry.off_x = coord_ff[0][6:0];
                     vleft_in    = vleft_ff - 32'd1;
                     if (vleft_in == '0) begin
                        entry.fin = 1'b1;
                        done_in   = 1'b1;
                     end
                  end
               end
            end
            default: begin
               done_in = 1'b1;
            end
         endcase
         // every error closes the stream
         if (have && entry.kind == KIND_ERROR) begin
            entry.fin = 1'b1;
            done_in   = 1'b1;
         end
      end

      // last beat: flag an early end, then start over
      if (take && req.last_byte) begin
         if (!done_ff && !(have && entry.fin)) begin
            have       = 1'b1;
            entry      = '0;
            entry.kind = KIND_ERROR;
            entry.err  = ERR_EARLY;
            entry.fin  = 1'b1;
         end
         phase_in  = PH_HDR;
         cnt_in    = '0;
         tag_in    = '0;
         gather_in = '0;
         skip_in   = '0;
         ext_in    = '{default: '0};
         vleft_in  = '0;
         coord_in  = '{default: '0};
         done_in   = 1'b0;
      end
   end

   assign push = take && have;

   // Parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR;
         cnt_ff    <= '0;
         tag_ff    <= '0;
         gather_ff <= '0;
         skip_ff   <= '0;
         ext_ff    <= '{default: '0};
         vleft_ff  <= '0;
         coord_ff  <= '{default: '0};
         done_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         tag_ff    <= tag_in;
         gather_ff <= gather_in;
         skip_ff   <= skip_in;
         ext_ff    <= ext_in;
         vleft_ff  <= vleft_in;
         coord_ff  <= coord_in;
         done_ff   <= done_in;
      end
   end

endmodule

// ===== src/vox_fifo.sv =====
module vox_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  vox_pkg::vox_entry_type push_data,
   input  logic                   pop,
   output vox_pkg::vox_entry_type pop_data,
   output logic                   not_empty,
   output logic                   full
);
   import vox_pkg::*;

   vox_entry_type         slot_ff [VOX_QDEPTH];
   logic [VOX_QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [VOX_QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [VOX_QCNT_W-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == VOX_QCNT_W'(VOX_QDEPTH));
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == VOX_QPTR_W'(VOX_QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == VOX_QPTR_W'(VOX_QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== src/vox_back.sv =====
module vox_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  vox_pkg::vox_entry_type q_entry,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output vox_pkg::vox_rsp_type   rsp_payload
);
   import vox_pkg::*;

   logic          s1_valid_ff;
   vox_entry_type s1_entry_ff;
   logic [14:0]   s1_part_ff;
   logic          out_valid_ff;
   vox_rsp_type   out_ff, out_in;
   logic          advance_out;
   logic          s1_load;
   logic [22:0]   full_addr;

   assign advance_out = !out_valid_ff || !rsp_stall;
   assign s1_load     = !s1_valid_ff || advance_out;
   assign q_pop       = q_valid && s1_load;

   // Second multiply: row offset times x extent plus x
   assign full_addr = 23'(s1_part_ff) * 23'(s1_entry_ff.scale) + 23'(s1_entry_ff.off_x);

   always_comb begin
      out_in               = '0;
      out_in.result_kind   = s1_entry_ff.kind;
      out_in.write_address = full_addr[20:0];
      out_in.voxel_value   = s1_entry_ff.value;
      out_in.size_x        = s1_entry_ff.sx;
      out_in.size_y        = s1_entry_ff.sy;
      out_in.size_z        = s1_entry_ff.sz;
      out_in.error_code    = s1_entry_ff.err;
      out_in.final_result  = s1_entry_ff.fin;
   end

   // Pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance_out) out_valid_ff <= s1_valid_ff;
         if (s1_load) s1_valid_ff <= q_valid;
      end
   end

   // Pipeline data; first multiply folds the slower axes together
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_entry_ff <= q_entry;
         s1_part_ff  <= 15'(q_entry.mul_a) * 15'(q_entry.mul_b) + 15'(q_entry.add_c);
      end
      if (advance_out && s1_valid_ff) out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// ===== src/vox_voxel_stream_parser.sv =====
// Voxel model file parser. Feed the file one byte per beat on the req_ channel,
// marking its final byte with last_byte; each beat is parsed in the cycle it is
// accepted, so a byte can be taken every clock while req_stall is low. A beat
// yields at most one result beat on the rsp_ channel: the model dimensions, one
// dense-array write (address with x fastest, value), an empty-model notice or an
// error, and the last result of a file carries final_result. Results pass through
// a two-deep queue and a two-stage address multiply; req_stall rises only when
// that queue is full because rsp_stall holds results back. csr_write_data sets
// the Y/Z swap (reset on); the user must see that it is written only between
// files, as the block itself does not enforce it.
module vox_voxel_stream_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  vox_pkg::vox_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output vox_pkg::vox_rsp_type rsp_payload,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data
);
   import vox_pkg::*;

   logic          swap_ff;
   logic          q_full;
   logic          take;
   logic          push;
   vox_entry_type push_entry;
   logic          q_valid;
   logic          q_pop;
   vox_entry_type q_entry;

   // Axis swap register
   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff <= 1'b1;
      end else if (csr_write_enable) begin
         swap_ff <= csr_write_data;
      end
   end

   assign req_stall = q_full;
   assign take      = req_valid && !req_stall;

   vox_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req      (req_payload),
      .swap_y_z (swap_ff),
      .push     (push),
      .entry    (push_entry)
   );

   vox_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (q_pop),
      .pop_data  (q_entry),
      .not_empty (q_valid),
      .full      (q_full)
   );

   vox_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/sv/vox_result_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the voxel parser, tracks the parse of the byte
// stream on its own, and compares every result beat with the oldest predicted
// one. Mismatches are counted and handed to the top.
module vox_result_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  vox_pkg::vox_req_type req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  vox_pkg::vox_rsp_type rsp_payload,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data,
   output int                   fail_count,
   output int                   results_pending
);
   import vox_pkg::*;

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_SKIP4,
      PH_CHUNK_HDR,
      PH_SKIP_CHUNK,
      PH_DIMS,
      PH_XYZI_HDR,
      PH_COUNT,
      PH_VOXELS
   } parse_phase_type;

   // File header bytes, byte 0 in the low bits
   localparam logic [127:0] FILE_MAGIC = 128'h0000_0000_4E49_414D_0000_0096_2058_4F56;

   // Parse state of the stream being tracked
   parse_phase_type phase;
   logic [4:0]   byte_cnt;
   logic [31:0]  tag_acc;
   logic [31:0]  word_acc;
   logic [32:0]  skip_left;
   logic [7:0]   extent [3];
   logic [31:0]  voxels_left;
   logic [7:0]   coord [3];
   bit           stream_done;
   bit           swap_yz;

   vox_rsp_type  predicted_results [$];
   vox_rsp_type  seen_beat;
   vox_rsp_type  oldest_beat;
   vox_rsp_type  new_beat;
   bit           new_valid;
   string        bad_fields;
   int unsigned  result_index;

   task automatic clear_parse();
      phase       = PH_HEADER;
      byte_cnt    = '0;
      tag_acc     = '0;
      word_acc    = '0;
      skip_left   = '0;
      extent      = '{default: '0};
      voxels_left = '0;
      coord       = '{default: '0};
      stream_done = 1'b0;
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t ns: result beat %0d: %s", $time, result_index, what);
      fail_count++;
   endtask

   function automatic string show(input vox_rsp_type r);
      return $sformatf("kind %0d addr %0d value %0d size %0d/%0d/%0d err %0d final %0b",
                       r.result_kind, r.write_address, r.voxel_value, r.size_x,
                       r.size_y, r.size_z, r.error_code, r.final_result);
   endfunction

   // Advance the parse by one byte; have is set when the byte yields a result
   task automatic parse_beat(input logic [7:0] b, input logic last,
                             output bit have, output vox_rsp_type r);
      bit          fin;
      bit          was_done;
      logic [4:0]  cnt;
      int unsigned cx, cy, cz, ex, ey, ez, addr;
      have     = 1'b0;
      fin      = 1'b0;
      was_done = stream_done;
      r        = '0;
      cnt      = byte_cnt;
      if (!stream_done) begin
         case (phase)
            PH_HEADER: begin
               // bit 0 of the word collects any header mismatch
               if (b != FILE_MAGIC[8 * cnt[3:0] +: 8]) word_acc[0] = 1'b1;
               byte_cnt = cnt + 1;
               if (byte_cnt >= 16) begin
                  if (word_acc[0]) begin
                     have = 1'b1;
                     r.result_kind = KIND_ERROR;
                     r.error_code  = ERR_HEADER;
                  end
                  phase    = PH_SKIP4;
                  byte_cnt = '0;
                  word_acc = '0;
               end
            end
            PH_SKIP4: begin
               byte_cnt = cnt + 1;
               if (byte_cnt >= 4) begin
                  phase    = PH_CHUNK_HDR;
                  byte_cnt = '0;
               end
            end
            PH_CHUNK_HDR, PH_XYZI_HDR: begin
               // tag big-endian, then two little-endian sizes
               if (cnt < 4) tag_acc = {tag_acc[23:0], b};
               else word_acc |= 32'(b) << (8 * cnt[1:0]);
               if (cnt == 7) begin
                  skip_left = {1'b0, word_acc};
                  word_acc  = '0;
               end
               byte_cnt = cnt + 1;
               if (cnt >= 11) begin
                  skip_left = skip_left + 33'(word_acc);
                  word_acc  = '0;
                  byte_cnt  = '0;
                  if (phase == PH_XYZI_HDR) begin
                     if (tag_acc != TAG_XYZI) begin
                        have = 1'b1;
                        r.result_kind = KIND_ERROR;
                        r.error_code  = ERR_NO_XYZI;
                     end else begin
                        phase = PH_COUNT;
                     end
                  end else if (tag_acc == TAG_SIZE) begin
                     phase = PH_DIMS;
                  end else if (skip_left != 0) begin
                     phase = PH_SKIP_CHUNK;
                  end
                  if (phase != PH_SKIP_CHUNK) skip_left = '0;
                  tag_acc = '0;
               end
            end
            PH_SKIP_CHUNK: begin
               if (skip_left != 0) skip_left = skip_left - 1;
               if (skip_left == 0) phase = PH_CHUNK_HDR;
            end
            PH_DIMS: begin
               word_acc |= 32'(b) << (8 * cnt[1:0]);
               if (cnt[1:0] == 2'd3) begin
                  extent[cnt[3:2]] = (word_acc >= 1 && word_acc <= MAX_DIM) ?
                                     word_acc[7:0] : 8'd0;
                  word_acc = '0;
               end
               byte_cnt = cnt + 1;
               if (cnt >= 11) begin
                  byte_cnt = '0;
                  have     = 1'b1;
                  if (extent[0] == 0 || extent[1] == 0 || extent[2] == 0) begin
                     r.result_kind = KIND_ERROR;
                     r.error_code  = ERR_DIMS;
                  end else begin
                     r.result_kind = KIND_DIMS;
                     r.size_x = extent[0];
                     r.size_y = swap_yz ? extent[2] : extent[1];
                     r.size_z = swap_yz ? extent[1] : extent[2];
                     phase    = PH_XYZI_HDR;
                  end
               end
            end
            PH_COUNT: begin
               word_acc |= 32'(b) << (8 * cnt[1:0]);
               byte_cnt = cnt + 1;
               if (cnt >= 3) begin
                  voxels_left = word_acc;
                  word_acc    = '0;
                  byte_cnt    = '0;
                  // zero or negative count: nothing to place
                  if (voxels_left == 0 || voxels_left[31]) begin
                     have = 1'b1;
                     fin  = 1'b1;
                     stream_done   = 1'b1;
                     r.result_kind = KIND_EMPTY;
                  end else begin
                     phase = PH_VOXELS;
                  end
               end
            end
            PH_VOXELS: begin
               if (cnt < 3) begin
                  coord[cnt[1:0]] = b;
                  byte_cnt = cnt + 1;
               end else begin
                  byte_cnt = '0;
                  have     = 1'b1;
                  cx = coord[0];
                  cy = coord[1];
                  cz = coord[2];
                  ex = extent[0];
                  ey = extent[1];
                  ez = extent[2];
                  if (cx >= 128 || cy >= 128 || cz >= 128 ||
                      cx >= ex || cy >= ey || cz >= ez) begin
                     r.result_kind = KIND_ERROR;
                     r.error_code  = ERR_BOUNDS;
                  end else begin
                     r.result_kind = KIND_WRITE;
                     r.voxel_value = b;
                     if (swap_yz) addr = (cy * ez + cz) * ex + cx;
                     else addr = (cz * ey + cy) * ex + cx;
                     r.write_address = 21'(addr);
                     voxels_left = voxels_left - 1;
                     if (voxels_left == 0) begin
                        fin = 1'b1;
                        stream_done = 1'b1;
                     end
                  end
               end
            end
            default: begin
               stream_done = 1'b1;
            end
         endcase
         if (have && r.result_kind == KIND_ERROR) begin
            fin = 1'b1;
            stream_done = 1'b1;
         end
      end

      // Stream end: an unfinished file turns into an early-end error
      if (last) begin
         if (!was_done && !(have && fin)) begin
            have = 1'b1;
            fin  = 1'b1;
            r    = '0;
            r.result_kind = KIND_ERROR;
            r.error_code  = ERR_EARLY;
         end
         clear_parse();
      end
      r.final_result = fin;
   endtask

   // Compare result beats first, then predict from the accepted byte
   always @(posedge clock) begin
      if (reset) begin
         predicted_results.delete();
         clear_parse();
         swap_yz         = 1'b1;
         fail_count      = 0;
         results_pending = 0;
         result_index    = 0;
      end else begin
         if (csr_write_enable) swap_yz = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            seen_beat = rsp_payload;
            if (predicted_results.size() == 0) begin
               report_mismatch({"no result expected, got ", show(seen_beat)});
            end else begin
               oldest_beat = predicted_results.pop_front();
               bad_fields  = "";
               if (seen_beat.result_kind !== oldest_beat.result_kind)
                  bad_fields = {bad_fields, " kind"};
               if (seen_beat.write_address !== oldest_beat.write_address)
                  bad_fields = {bad_fields, " address"};
               if (seen_beat.voxel_value !== oldest_beat.voxel_value)
                  bad_fields = {bad_fields, " value"};
               if (seen_beat.size_x !== oldest_beat.size_x)
                  bad_fields = {bad_fields, " size_x"};
               if (seen_beat.size_y !== oldest_beat.size_y)
                  bad_fields = {bad_fields, " size_y"};
               if (seen_beat.size_z !== oldest_beat.size_z)
                  bad_fields = {bad_fields, " size_z"};
               if (seen_beat.error_code !== oldest_beat.error_code)
                  bad_fields = {bad_fields, " error"};
               if (seen_beat.final_result !== oldest_beat.final_result)
                  bad_fields = {bad_fields, " final"};
               if (bad_fields.len() != 0)
                  report_mismatch({"mismatch in", bad_fields, ": got ", show(seen_beat),
                                   "; expected ", show(oldest_beat)});
            end
            result_index++;
         end
         if (req_valid && !req_stall) begin
            parse_beat(req_payload.data_byte, req_payload.last_byte, new_valid, new_beat);
            if (new_valid) predicted_results.push_back(new_beat);
         end
         results_pending = predicted_results.size();
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

// Feeds voxel model files, well-formed and broken, into the parser with
// random burst gaps and result stalls, switching the Y/Z swap between phases.
module testbench;
   import vox_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned RANDOM_BYTES = 300;

   localparam logic [31:0] FILE_TAG_VOX  = 32'h564F_5820;
   localparam logic [31:0] FILE_TAG_MAIN = 32'h4D41_494E;
   localparam logic [31:0] FILE_VERSION  = 32'd150;
   localparam logic [31:0] TAG_PACK      = 32'h5041_434B;
   localparam logic [31:0] TAG_RGBA      = 32'h5247_4241;

   typedef enum int {
      FLAW_NONE,
      FLAW_HEADER,
      FLAW_DIMS,
      FLAW_TAG,
      FLAW_BOUNDS,
      FLAW_COUNT,
      FLAW_SHORT,
      FLAW_NOISE
   } flaw_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_LONG,
      STALL_HEAVY
   } stall_mode_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   vox_req_type req_payload      = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   vox_rsp_type rsp_payload;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data   = 1'b0;
   int          fail_count;
   int          results_pending;
   int unsigned cycle_count      = 0;

   logic [7:0]  file_bytes [$];
   vox_req_type byte_beats [$];
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned stall_hold = 0;

   vox_voxel_stream_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   vox_result_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .results_pending  (results_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Byte sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (byte_beats.size() != 0) begin
            req_payload <= byte_beats.pop_front();
            req_valid   <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall pattern, mode changes now and then
   always @(posedge clock) begin
      if ($urandom_range(0, 299) == 0) stall_mode = stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_LIGHT: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         STALL_LONG: begin
            if (stall_hold == 0) begin
               rsp_stall <= !rsp_stall;
               stall_hold = $urandom_range(1, 20);
            end else begin
               stall_hold = stall_hold - 1;
            end
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 1) == 0);
         end
      endcase
   end

   // File building helpers
   task automatic put_byte(input logic [7:0] b);
      file_bytes.push_back(b);
   endtask

   task automatic put_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++) put_byte(w[8 * i +: 8]);
   endtask

   task automatic put_tag(input logic [31:0] t);
      for (int i = 3; i >= 0; i--) put_byte(t[8 * i +: 8]);
   endtask

   task automatic put_header(input bit corrupt);
      int unsigned pos;
      put_tag(FILE_TAG_VOX);
      put_word(FILE_VERSION);
      put_tag(FILE_TAG_MAIN);
      put_word(32'd0);
      if (corrupt) begin
         pos = $urandom_range(0, 15);
         file_bytes[pos] = file_bytes[pos] ^ 8'($urandom_range(1, 255));
      end
      put_word($urandom);
   endtask

   task automatic put_chunk(input logic [31:0] tag, input int unsigned content,
                            input int unsigned children);
      put_tag(tag);
      put_word(content);
      put_word(children);
      repeat (content + children) put_byte(8'($urandom));
   endtask

   task automatic put_dims(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      put_tag(TAG_SIZE);
      put_word($urandom);
      put_word($urandom);
      put_word(x);
      put_word(y);
      put_word(z);
   endtask

   task automatic put_voxel_head(input logic [31:0] tag, input logic [31:0] count);
      put_tag(tag);
      put_word($urandom);
      put_word($urandom);
      put_word(count);
   endtask

   task automatic put_voxel(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z,
                            input logic [7:0] v);
      put_byte(x);
      put_byte(y);
      put_byte(z);
      put_byte(v);
   endtask

   // Hand the built file to the sender, last byte marked
   task automatic commit_file();
      vox_req_type beat;
      for (int i = 0; i < file_bytes.size(); i++) begin
         beat.data_byte = file_bytes[i];
         beat.last_byte = (i == file_bytes.size() - 1);
         byte_beats.push_back(beat);
      end
      file_bytes.delete();
   endtask

   function automatic logic [31:0] pick_dim();
      case ($urandom_range(0, 9))
         0:       return 32'd128;
         1:       return 32'd1;
         2, 3:    return $urandom_range(1, 128);
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   function automatic logic [31:0] pick_bad_dim();
      case ($urandom_range(0, 4))
         0:       return 32'd0;
         1:       return $urandom_range(129, 255);
         2:       return 256 * $urandom_range(1, 255);
         3:       return $urandom | 32'h8000_0000;
         default: return $urandom | 32'h0000_0100;
      endcase
   endfunction

   // Largest model with voxels on opposite corners and on an edge
   task automatic corner_file();
      put_header(1'b0);
      put_dims(128, 128, 128);
      put_voxel_head(TAG_XYZI, 3);
      put_voxel(0, 0, 0, 8'h80);
      put_voxel(127, 127, 127, 8'h7F);
      put_voxel(127, 0, 64, 8'h01);
      commit_file();
   endtask

   task automatic build_file(input flaw_type flaw);
      logic [31:0] dim_word [3];
      logic [7:0]  pos [3];
      int unsigned nvox, bad_vox, bad_axis, cut;
      file_bytes.delete();
      if (flaw == FLAW_NOISE) begin
         repeat ($urandom_range(1, 40)) put_byte(8'($urandom));
         return;
      end
      put_header(flaw == FLAW_HEADER);
      repeat ($urandom_range(0, 2)) put_chunk($urandom, $urandom_range(0, 5),
                                              $urandom_range(0, 3));
      for (int a = 0; a < 3; a++) dim_word[a] = pick_dim();
      bad_axis = $urandom_range(0, 2);
      if (flaw == FLAW_DIMS) dim_word[bad_axis] = pick_bad_dim();
      put_dims(dim_word[0], dim_word[1], dim_word[2]);
      nvox = $urandom_range(1, 8);
      if (flaw == FLAW_COUNT)
         put_voxel_head(TAG_XYZI, ($urandom_range(0, 1) == 0) ? 0 : ($urandom | 32'h8000_0000));
      else
         put_voxel_head((flaw == FLAW_TAG) ? $urandom : TAG_XYZI, nvox);
      bad_vox = $urandom_range(0, nvox - 1);
      for (int i = 0; i < nvox; i++) begin
         for (int a = 0; a < 3; a++) begin
            if (dim_word[a] >= 1 && dim_word[a] <= MAX_DIM)
               pos[a] = 8'($urandom_range(0, dim_word[a] - 1));
            else
               pos[a] = 8'($urandom);
         end
         // one coordinate at its extent or negative
         if (flaw == FLAW_BOUNDS && i == bad_vox)
            pos[bad_axis] = ($urandom_range(0, 1) == 0) ? dim_word[bad_axis][7:0] :
                            8'($urandom_range(128, 255));
         put_voxel(pos[0], pos[1], pos[2], 8'($urandom));
      end
      // bytes after the last voxel are dropped by the parser
      if (flaw == FLAW_NONE && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
      if (flaw == FLAW_SHORT) begin
         cut = $urandom_range(1, file_bytes.size() - 1);
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
   endtask

   task automatic run_directed();
      corner_file();
      // smallest model after an empty chunk and a chunk with children; trailing bytes
      put_header(1'b0);
      put_chunk(TAG_PACK, 0, 0);
      put_chunk(TAG_RGBA, 3, 2);
      put_dims(1, 1, 1);
      put_voxel_head(TAG_XYZI, 1);
      put_voxel(0, 0, 0, 8'hFF);
      put_byte(8'h5A);
      put_byte(8'hA5);
      commit_file();
      // broken header
      put_header(1'b1);
      commit_file();
      // bad dimensions: zero, above the maximum, negative, low byte clear
      put_header(1'b0);
      put_dims(0, 5, 5);
      commit_file();
      put_header(1'b0);
      put_dims(4, 129, 4);
      commit_file();
      put_header(1'b0);
      put_dims(3, 3, 32'hFFFF_FFFF);
      commit_file();
      put_header(1'b0);
      put_dims(2, 2, 256);
      commit_file();
      // chunk after SIZE is not XYZI
      put_header(1'b0);
      put_dims(2, 3, 4);
      put_voxel_head(TAG_RGBA, 1);
      put_voxel(1, 1, 1, 8'h11);
      commit_file();
      // negative coordinate, then coordinate equal to its extent
      put_header(1'b0);
      put_dims(4, 4, 4);
      put_voxel_head(TAG_XYZI, 3);
      put_voxel(1, 2, 3, 8'h07);
      put_voxel(0, 8'h80, 0, 8'h01);
      commit_file();
      put_header(1'b0);
      put_dims(5, 6, 7);
      put_voxel_head(TAG_XYZI, 2);
      put_voxel(4, 5, 6, 8'h09);
      put_voxel(0, 0, 7, 8'h01);
      commit_file();
      // empty model: zero count, negative count with a trailing byte
      put_header(1'b0);
      put_dims(2, 2, 2);
      put_voxel_head(TAG_XYZI, 0);
      commit_file();
      put_header(1'b0);
      put_dims(2, 2, 2);
      put_voxel_head(TAG_XYZI, 32'h8000_0000);
      put_byte(8'h00);
      commit_file();
      // stream ends on a non-final voxel write
      put_header(1'b0);
      put_dims(3, 3, 3);
      put_voxel_head(TAG_XYZI, 4);
      put_voxel(1, 1, 1, 8'h02);
      put_voxel(2, 2, 2, 8'h03);
      commit_file();
      // stream ends inside a chunk with the largest sizes
      put_header(1'b0);
      put_tag(TAG_PACK);
      put_word(32'hFFFF_FFFF);
      put_word(32'hFFFF_FFFF);
      repeat (5) put_byte(8'($urandom));
      commit_file();
      // lone byte, and a stream that ends on the dimensions byte
      put_byte(8'h56);
      commit_file();
      put_header(1'b0);
      put_dims(8, 1, 2);
      commit_file();
   endtask

   task automatic run_random(input int unsigned nbytes);
      int unsigned sent;
      flaw_type    flaw;
      sent = 0;
      while (sent < nbytes) begin
         flaw = ($urandom_range(0, 99) < 60) ? FLAW_NONE : flaw_type'($urandom_range(1, 7));
         build_file(flaw);
         sent += file_bytes.size();
         commit_file();
      end
   endtask

   // Wait until every byte is taken and every result has come back
   task automatic settle();
      do @(negedge clock); while (byte_beats.size() != 0 || req_valid);
      while (results_pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_swap(input logic value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_swap(1'b1);
      run_directed();
      settle();
      write_swap(1'b0);
      corner_file();
      run_random(RANDOM_BYTES / 4);
      settle();
      write_swap(1'b1);
      run_random(RANDOM_BYTES / 4);
      settle();
      write_swap(1'b0);
      run_random(RANDOM_BYTES / 4);
      settle();
      write_swap(1'b1);
      corner_file();
      run_random(RANDOM_BYTES / 4);
      settle();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
